// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the pair-sum bitmap stream checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define PSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pair-sum stream assertion failed");

// Property checked at every rising edge, reset included.
`define PSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pair-sum stream assertion failed");

`endif

// ===== sv/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// psb_pkg
// Types and fixed widths shared by the pair-sum bitmap stream modules.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int VALUE_W  = 10;
  localparam int TARGET_W = 11;
  localparam int DIFF_W   = TARGET_W + 1;

  // Set tag stored per bitmap entry. Tag zero never matches a live set.
  localparam int EPOCH_W = 6;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] partner;
    logic               partner_ok;
    logic               mark_ok;
    logic               last;
  } item_t;

endpackage

// ===== sv/psb_front.sv =====
// ----------------------------------------------------------------------------
// psb_front
// Accepts input elements, holds the target sum and classifies each element.
// ----------------------------------------------------------------------------
module psb_front #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [psb_pkg::TARGET_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psb_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_last_in_set,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          push,
  output psb_pkg::item_t                push_item
);

  localparam int MAP_DEPTH = (VALUE_RANGE < (1 << psb_pkg::VALUE_W)) ?
                             VALUE_RANGE : (1 << psb_pkg::VALUE_W);
  localparam logic [psb_pkg::DIFF_W-1:0] DEPTH_LIM = psb_pkg::DIFF_W'(MAP_DEPTH);

  logic [psb_pkg::TARGET_W-1:0] target_r;
  logic [psb_pkg::DIFF_W-1:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  // A negative difference sets the top bit and so also fails the range check.
  assign diff     = {1'b0, target_r} - psb_pkg::DIFF_W'(in_value);
  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.value      = in_value;
    push_item.partner    = diff[psb_pkg::VALUE_W-1:0];
    push_item.partner_ok = diff < DEPTH_LIM;
    push_item.mark_ok    = psb_pkg::DIFF_W'(in_value) < DEPTH_LIM;
    push_item.last       = in_last_in_set;
  end

endmodule

// ===== sv/psb_fifo.sv =====
// ----------------------------------------------------------------------------
// psb_fifo
// Short queue of classified elements between the front and the back.
// ----------------------------------------------------------------------------
module psb_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psb_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output psb_pkg::item_t q_item
);

  psb_pkg::item_t              slots_r [psb_pkg::QUEUE_DEPTH];
  logic [psb_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [psb_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [psb_pkg::QCNT_W-1:0]  count_r;
  logic [psb_pkg::QCNT_W-1:0]  count_nxt;

  assign full    = count_r == psb_pkg::QCNT_W'(psb_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + psb_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - psb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + psb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + psb_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/psb_back.sv =====
// ----------------------------------------------------------------------------
// psb_back
// Looks up the partner in the tagged presence map, marks the element and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module psb_back #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  psb_pkg::item_t               q_item,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psb_pkg::VALUE_W-1:0]  out_value_res,
  output logic [psb_pkg::VALUE_W-1:0]  out_partner
);

  localparam int MAP_DEPTH = (VALUE_RANGE < (1 << psb_pkg::VALUE_W)) ?
                             VALUE_RANGE : (1 << psb_pkg::VALUE_W);
  localparam int ADDR_W = $clog2(MAP_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAP_DEPTH - 1);

  // Each entry holds the tag of the set that last marked it.
  logic [psb_pkg::EPOCH_W-1:0] map_mem [MAP_DEPTH];

  logic [psb_pkg::EPOCH_W-1:0] epoch_r;
  logic                        clearing_r;
  logic [ADDR_W-1:0]           clr_addr_r;

  logic                        s2_valid_r;
  logic [psb_pkg::VALUE_W-1:0] s2_value_r;
  logic [psb_pkg::VALUE_W-1:0] s2_partner_r;
  logic                        s2_ok_r;
  logic [psb_pkg::EPOCH_W-1:0] s2_epoch_r;
  logic [psb_pkg::EPOCH_W-1:0] rd_tag_r;

  logic                        s2_hit;
  logic                        s2_free;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [psb_pkg::EPOCH_W-1:0] wr_tag;
  logic [ADDR_W-1:0]           rd_addr;

  assign s2_hit  = s2_valid_r && s2_ok_r && (rd_tag_r == s2_epoch_r);
  assign s2_free = !s2_hit || out_ready;
  assign pop     = q_valid && !clearing_r && s2_free;

  assign clearing      = clearing_r;
  assign out_valid     = s2_hit;
  assign out_value_res = s2_value_r;
  assign out_partner   = s2_partner_r;

  assign rd_addr = q_item.partner[ADDR_W-1:0];

  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_tag  = psb_pkg::EPOCH_NONE;
    end else begin
      wr_en   = pop && q_item.mark_ok;
      wr_addr = q_item.value[ADDR_W-1:0];
      wr_tag  = epoch_r;
    end
  end

  // Read-first port: an element that is its own partner sees the old tag.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_tag_r <= map_mem[rd_addr];
    end
    if (wr_en) begin
      map_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r    <= psb_pkg::EPOCH_FIRST;
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      if (pop && q_item.last) begin
        if (epoch_r == psb_pkg::EPOCH_LAST) begin
          epoch_r    <= psb_pkg::EPOCH_FIRST;
          clearing_r <= 1'b1;
          clr_addr_r <= '0;
        end else begin
          epoch_r <= epoch_r + psb_pkg::EPOCH_W'(1);
        end
      end
      if (s2_free) begin
        s2_valid_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_value_r   <= q_item.value;
      s2_partner_r <= q_item.partner;
      s2_ok_r      <= q_item.partner_ok;
      s2_epoch_r   <= epoch_r;
    end
  end

endmodule

// ===== sv/pair_sum_bitmap_stream.sv =====
// ----------------------------------------------------------------------------
// pair_sum_bitmap_stream
// Streaming pair-sum detector over sets of unsigned values.
// ----------------------------------------------------------------------------
// Usage: elements enter on the in_ channel (valid/ready) and a result leaves
// on the out_ channel (valid/ready) whenever an element and an earlier element
// of the same set add up to the target sum written through cfg_wr_en and
// cfg_wr_data. Each input transfer gives zero or one output transfer.
// An element flagged in_last_in_set closes its set; later elements start over.
// Results leave from a register. Throughput is one element per cycle while no
// clearing pass or receiver stall holds the queue, set by the single read and
// single write port of the presence map, which are used in the same cycle.
// The presence map is a memory of set tags, so closing a set costs nothing.
// After reset, and again after every 63rd closed set when the tags wrap,
// a clearing pass rewrites all min(VALUE_RANGE, 1024) map entries; in_ready
// stays low during the pass. When the receiver stalls, the result register
// holds its transfer and the four-entry queue absorbs further input before
// in_ready drops. Write the target only while the block is idle.
// ----------------------------------------------------------------------------
module pair_sum_bitmap_stream #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [psb_pkg::TARGET_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psb_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_last_in_set,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psb_pkg::VALUE_W-1:0]   out_value_res,
  output logic [psb_pkg::VALUE_W-1:0]   out_partner
);

  logic           push;
  psb_pkg::item_t push_item;
  logic           q_full;
  logic           q_valid;
  psb_pkg::item_t q_item;
  logic           pop;
  logic           clearing;

  // The front computes the partner and both range checks at the transfer.
  psb_front #(
    .VALUE_RANGE (VALUE_RANGE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_last_in_set (in_last_in_set),
    .q_full         (q_full),
    .clearing       (clearing),
    .push           (push),
    .push_item      (push_item)
  );

  // The queue lets the front keep taking elements while a result waits.
  psb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // The back reads the partner's tag and marks the element in the same cycle.
  psb_back #(
    .VALUE_RANGE (VALUE_RANGE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_partner   (out_partner)
  );

endmodule

// ===== sv/psb_checker.sv =====
// ----------------------------------------------------------------------------
// psb_checker
// Port-level checks for the pair-sum bitmap stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psb_pkg::VALUE_W-1:0]  out_value_res,
  input logic [psb_pkg::VALUE_W-1:0]  out_partner
);

  // A stalled result keeps its valid and its payload.
  `PSB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `PSB_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable({out_value_res, out_partner}))

  // Reset empties the pipeline and starts the clearing pass.
  `PSB_ASSERT_ALWAYS(a_rst_no_input, clk, !rst_n |=> !in_ready)
  `PSB_ASSERT_ALWAYS(a_rst_no_output, clk, !rst_n |=> !out_valid)

endmodule

bind pair_sum_bitmap_stream psb_checker u_psb_checker (.*);

// ===== dv/tb_pair_sum_bitmap_stream.sv =====
// ----------------------------------------------------------------------------
// tb_pair_sum_bitmap_stream
// Self-checking bench for the streaming pair-sum detector.
// ----------------------------------------------------------------------------
// A short scripted sequence walks the corner cases first: the reset target,
// the largest target and values, partners that fall below zero or past the
// end of the map, an element that must not pair with itself, and the map
// clear after a closed set. Random phases follow, each with its own target,
// built mostly from sets that deliberately contain partners of earlier
// elements so that pairs are common. Output transfers are compared in order
// against a local presence map's predictions or a scripted row's typed result.
// ----------------------------------------------------------------------------
module tb_pair_sum_bitmap_stream;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int VALUE_RANGE  = 1024;
  localparam int ITEM_GOAL    = 1050;
  // Cycles allowed for the pipeline and its queue to go quiet, since an
  // element without a pair leaves nothing to wait for.
  localparam int DRAIN_CYCLES = 8;
  // The clearing pass after reset and after every tag wrap keeps in_ready low
  // over all 1024 map entries; stalls and gaps stay far below this limit.
  localparam int STALL_LIMIT  = 4096;
  localparam int SCRIPT_LEN   = 26;

  // How a scripted row is handled: a target write, an element whose result
  // comes from the predictor, or an element with its outcome typed in.
  typedef enum logic [1:0] {
    DO_CFG,
    DO_PREDICT,
    DO_NONE,
    DO_PAIR
  } row_op_t;

  typedef struct packed {
    row_op_t                      op;
    logic [psb_pkg::TARGET_W-1:0] arg;
    logic                         last;
    logic [psb_pkg::VALUE_W-1:0]  res_value;
    logic [psb_pkg::VALUE_W-1:0]  res_partner;
  } script_row_t;

  typedef struct packed {
    logic [psb_pkg::VALUE_W-1:0] value_res;
    logic [psb_pkg::VALUE_W-1:0] partner;
  } pair_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         cfg_wr_en      = 1'b0;
  logic [psb_pkg::TARGET_W-1:0] cfg_wr_data    = '0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [psb_pkg::VALUE_W-1:0]  in_value       = '0;
  logic                         in_last_in_set = 1'b0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [psb_pkg::VALUE_W-1:0]  out_value_res;
  logic [psb_pkg::VALUE_W-1:0]  out_partner;

  // Predictor state: the presence map of the open set and the target in use.
  bit                           presence [VALUE_RANGE];
  logic [psb_pkg::TARGET_W-1:0] target_q = '0;
  pair_t                        pairs_due[$];

  script_row_t script [SCRIPT_LEN];
  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  quiet_cycles   = 0;
  int  ready_left     = 0;
  // While set, neither side inserts gaps or stalls.
  bit  steady         = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  pair_sum_bitmap_stream #(
    .VALUE_RANGE(VALUE_RANGE)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_last_in_set(in_last_in_set),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_res (out_value_res),
    .out_partner   (out_partner)
  );

  // Applies one accepted element to the local presence map. The partner is
  // looked up before the element is marked, so an element never pairs with
  // itself. A typed row queues its written-in outcome instead of the
  // predicted one; the map is advanced either way.
  function automatic void track_element(logic [psb_pkg::VALUE_W-1:0] value, logic last,
                                        row_op_t op,
                                        logic [psb_pkg::VALUE_W-1:0] typed_value,
                                        logic [psb_pkg::VALUE_W-1:0] typed_partner);
    logic [psb_pkg::TARGET_W-1:0] diff;
    bit                           found;
    found = 1'b0;
    diff  = '0;
    // A target below the value means a negative partner: never found.
    if (target_q >= {1'b0, value}) begin
      diff = target_q - {1'b0, value};
      if (diff < VALUE_RANGE && presence[diff]) begin
        found = 1'b1;
      end
    end
    case (op)
      DO_PREDICT: begin
        if (found) begin
          pairs_due.push_back('{value_res: value,
                                partner: diff[psb_pkg::VALUE_W-1:0]});
        end
      end
      DO_PAIR: begin
        pairs_due.push_back('{value_res: typed_value, partner: typed_partner});
      end
      default: begin
      end
    endcase
    if (value < VALUE_RANGE) begin
      presence[value] = 1'b1;
    end
    // Closing the set empties the map for the next one.
    if (last) begin
      foreach (presence[i]) presence[i] = 1'b0;
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  // Element chooser for the random sets. Most picks complete a pair with an
  // element already sent in this set, some repeat an element, some cluster
  // around half the target, and the rest are free noise over the full range.
  function automatic logic [psb_pkg::VALUE_W-1:0] pick_value(
      logic [psb_pkg::TARGET_W-1:0] target, logic [psb_pkg::VALUE_W-1:0] pool[$]);
    int r;
    int base;
    logic [psb_pkg::VALUE_W-1:0] earlier;
    r = $urandom_range(99);
    if (pool.size() != 0 && r < 55) begin
      earlier = pool[$urandom_range(pool.size() - 1)];
      if (target >= {1'b0, earlier} && target - earlier < VALUE_RANGE) begin
        return psb_pkg::VALUE_W'(target - earlier);
      end
      return psb_pkg::VALUE_W'($urandom_range(VALUE_RANGE - 1));
    end else if (pool.size() != 0 && r < 65) begin
      return pool[$urandom_range(pool.size() - 1)];
    end else if (r < 80) begin
      base = int'(target / 2) + $urandom_range(8) - 4;
      if (base < 0) base = 0;
      if (base > VALUE_RANGE - 1) base = VALUE_RANGE - 1;
      return psb_pkg::VALUE_W'(base);
    end else begin
      return psb_pkg::VALUE_W'($urandom_range(VALUE_RANGE - 1));
    end
  endfunction

  // Offers one element and holds it until the transfer happens. Valid stays
  // high after the transfer when no gap follows, so back-to-back elements
  // never see valid lowered and raised in the same step.
  task automatic send_element(logic [psb_pkg::VALUE_W-1:0] value, logic last, row_op_t op,
                              logic [psb_pkg::VALUE_W-1:0] typed_value,
                              logic [psb_pkg::VALUE_W-1:0] typed_partner);
    int gap;
    in_valid       <= 1'b1;
    in_value       <= value;
    in_last_in_set <= last;
    do @(posedge clk); while (!in_ready);
    track_element(value, last, op, typed_value, typed_partner);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Nothing is in flight once every predicted result is back, any clearing
  // pass (in_ready low while no result waits) has ended and the queue has
  // had time to empty behind it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The target may only change while nothing is in flight.
  task automatic write_target(logic [psb_pkg::TARGET_W-1:0] target);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= target;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    target_q  = target;
  endtask

  // One random phase: a fresh target, then a handful of sets. A stray
  // set-closing flag in the middle of a set stands for a broken sequence.
  task automatic run_random_phase();
    logic [psb_pkg::TARGET_W-1:0] target;
    logic [psb_pkg::VALUE_W-1:0]  value;
    logic [psb_pkg::VALUE_W-1:0]  members[$];
    logic                         last;
    int                           n_sets;
    int                           set_len;
    case ($urandom_range(9))
      0:       target = '0;
      1:       target = psb_pkg::TARGET_W'(2046);
      2:       target = psb_pkg::TARGET_W'(1023);
      default: target = psb_pkg::TARGET_W'($urandom_range(2046));
    endcase
    write_target(target);
    steady = ($urandom_range(4) == 0);
    n_sets = $urandom_range(1, 6);
    for (int s = 0; s < n_sets; s++) begin
      members.delete();
      set_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int k = 0; k < set_len; k++) begin
        value = pick_value(target, members);
        last  = (k == set_len - 1) || ($urandom_range(39) == 0);
        send_element(value, last, DO_PREDICT, '0, '0);
        if (last) begin
          members.delete();
        end else begin
          members.push_back(value);
        end
      end
    end
    steady = 1'b0;
  endtask

  // Receiver side: runs of ready and of stall, mostly short with a few long
  // stalls. A steady phase keeps ready high throughout.
  always @(posedge clk) begin
    if (steady) begin
      out_ready  <= 1'b1;
      ready_left = 0;
    end else if (ready_left == 0) begin
      if ($urandom_range(1) == 0) begin
        out_ready  <= 1'b1;
        ready_left = $urandom_range(1, 12);
      end else begin
        out_ready  <= 1'b0;
        ready_left = ($urandom_range(19) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 3);
      end
    end else begin
      ready_left--;
    end
  end

  // Every output transfer is matched against the oldest pending pair.
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pairs_due.size() == 0) begin
        $error("unexpected out transfer: value_res %0d, partner %0d",
               out_value_res, out_partner);
        mismatch_count++;
      end else begin
        want = pairs_due.pop_front();
        if (out_value_res !== want.value_res) begin
          $error("value_res mismatch: expected %0d, actual %0d",
                 want.value_res, out_value_res);
          mismatch_count++;
        end
        if (out_partner !== want.partner) begin
          $error("partner mismatch: expected %0d, actual %0d",
                 want.partner, out_partner);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: the run is stuck if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Scripted corner cases. The first rows run on the reset target of zero.
    script = '{
      '{DO_NONE,    11'd0,    1'b0, 10'd0,    10'd0},    // first element, map empty
      '{DO_PAIR,    11'd0,    1'b0, 10'd0,    10'd0},    // zero pairs with earlier zero
      '{DO_NONE,    11'd1,    1'b1, 10'd0,    10'd0},    // partner negative, closes set
      '{DO_NONE,    11'd0,    1'b1, 10'd0,    10'd0},    // map was cleared
      '{DO_CFG,     11'd2046, 1'b0, 10'd0,    10'd0},
      '{DO_NONE,    11'd1023, 1'b0, 10'd0,    10'd0},
      '{DO_PAIR,    11'd1023, 1'b0, 10'd1023, 10'd1023}, // largest pair
      '{DO_NONE,    11'd0,    1'b0, 10'd0,    10'd0},    // partner past the map
      '{DO_PAIR,    11'd1023, 1'b1, 10'd1023, 10'd1023},
      '{DO_CFG,     11'd1023, 1'b0, 10'd0,    10'd0},
      '{DO_NONE,    11'd1023, 1'b0, 10'd0,    10'd0},
      '{DO_PAIR,    11'd0,    1'b0, 10'd0,    10'd1023},
      '{DO_NONE,    11'd512,  1'b0, 10'd0,    10'd0},
      '{DO_PAIR,    11'd511,  1'b0, 10'd511,  10'd512},
      '{DO_PAIR,    11'd1023, 1'b1, 10'd1023, 10'd0},
      '{DO_CFG,     11'd10,   1'b0, 10'd0,    10'd0},
      '{DO_NONE,    11'd5,    1'b0, 10'd0,    10'd0},    // must not pair with itself
      '{DO_PAIR,    11'd5,    1'b0, 10'd5,    10'd5},
      '{DO_NONE,    11'd3,    1'b1, 10'd0,    10'd0},
      '{DO_NONE,    11'd7,    1'b0, 10'd0,    10'd0},    // partner 3 was in the closed set
      '{DO_NONE,    11'd682,  1'b0, 10'd0,    10'd0},    // alternating bits, partner negative
      '{DO_NONE,    11'd341,  1'b1, 10'd0,    10'd0},
      '{DO_CFG,     11'd1500, 1'b0, 10'd0,    10'd0},
      '{DO_PREDICT, 11'd700,  1'b0, 10'd0,    10'd0},
      '{DO_PREDICT, 11'd800,  1'b0, 10'd0,    10'd0},
      '{DO_PREDICT, 11'd1000, 1'b1, 10'd0,    10'd0}
    };

    // Synchronous reset, held and then released once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == DO_CFG) begin
        write_target(script[i].arg);
      end else begin
        send_element(script[i].arg[psb_pkg::VALUE_W-1:0], script[i].last, script[i].op,
                     script[i].res_value, script[i].res_partner);
      end
    end

    while (items_sent < ITEM_GOAL) begin
      run_random_phase();
    end

    // Let the last results come out, then give the pipeline time to show
    // anything it should not produce.
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/psb_pkg.sv
sv/psb_front.sv
sv/psb_fifo.sv
sv/psb_back.sv
sv/pair_sum_bitmap_stream.sv
sv/psb_checker.sv
dv/tb_pair_sum_bitmap_stream.sv
